>>> hw/rtl/mfp_pkg.sv
`timescale 1ns / 1ps

package mfp_pkg;

   // Word geometry.
   localparam int WORD_BITS  = 32;
   localparam int FREE_BITS  = $clog2(WORD_BITS + 1);
   localparam int WIDTH_BITS = 5;

   // Field width after reset.
   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(8);

   // Depth of the queue between the packing front and the output back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // One input word.
   typedef struct packed {
      logic [31:0] value;
      logic        last_value;
   } req_type;

   // One result word.
   typedef struct packed {
      logic [WORD_BITS-1:0] packed_word;
      logic                 last_word;
   } rsp_type;

   // The results caused by one input word: none, one or two words. The second
   // word is always the flushed final word.
   typedef struct packed {
      logic [WORD_BITS-1:0] first_word;
      logic                 first_last;
      logic                 second_valid;
      logic [WORD_BITS-1:0] second_word;
   } entry_type;

   // Handshake between the queue and the back part.
   typedef struct packed {
      logic push;
      logic full;
      logic nonempty;
      logic pop;
   } queue_ctrl_type;

endpackage

>>> hw/rtl/msb_first_field_packer.sv
// A packed word goes out when an input field does not fit or a final word flushes it, passing
// through the queue and then the output register to rsp. Throughput: one input word per cycle
// while req_stall is low; the output register sends one word per cycle while rsp_stall is low,
// and an input that splits a field and flushes gives two words, held by the four-entry queue.
// Reset (synchronous, active high) empties the accumulator and queue and sets field width 8.
`timescale 1ns / 1ps

module msb_first_field_packer import mfp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [WIDTH_BITS-1:0] csr_data
);

   queue_ctrl_type qc;
   entry_type      push_entry;
   entry_type      head;

   assign csr_ready = 1'b1;
   assign req_stall = qc.full;

   // Packing front.
   mfp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (qc.full),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .push       (qc.push),
      .push_entry (push_entry)
   );

   // Queue of pending result entries.
   mfp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (qc.push),
      .push_entry (push_entry),
      .pop        (qc.pop),
      .full       (qc.full),
      .nonempty   (qc.nonempty),
      .head       (head)
   );

   // Output stage.
   mfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .nonempty  (qc.nonempty),
      .head      (head),
      .pop       (qc.pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/mfp_front.sv
`timescale 1ns / 1ps

module mfp_front import mfp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  req_type               req_data,
   input  logic                  queue_full,
   input  logic                  csr_valid,
   input  logic [WIDTH_BITS-1:0] csr_data,
   output logic                  push,
   output entry_type             push_entry
);

   logic [WIDTH_BITS-1:0] width_ff;
   logic [WORD_BITS-1:0]  acc_ff, acc_in;
   logic [FREE_BITS-1:0]  free_ff, free_in;

   logic                  accept;
   logic [WORD_BITS-1:0]  field;
   logic                  fits;
   logic [WIDTH_BITS-1:0] spill;
   logic [WORD_BITS-1:0]  split_word;
   logic [WORD_BITS-1:0]  acc_mid;
   logic [FREE_BITS-1:0]  free_mid;

   assign accept = req_valid && !queue_full;

   // Field width register, written from the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_valid) begin
         width_ff <= csr_data;
      end
   end

   // Merge the field into the word under construction, splitting it when it
   // does not fit in the bits still free.
   always_comb begin
      field      = req_data.value & ((WORD_BITS'(1) << width_ff) - WORD_BITS'(1));
      fits       = FREE_BITS'(width_ff) <= free_ff;
      spill      = width_ff - WIDTH_BITS'(free_ff);
      split_word = acc_ff | (field >> spill);
      if (fits) begin
         acc_mid  = acc_ff | (field << (free_ff - FREE_BITS'(width_ff)));
         free_mid = free_ff - FREE_BITS'(width_ff);
      end else begin
         acc_mid  = (field & ((WORD_BITS'(1) << spill) - WORD_BITS'(1)))
                    << (FREE_BITS'(WORD_BITS) - FREE_BITS'(spill));
         free_mid = FREE_BITS'(WORD_BITS) - FREE_BITS'(spill);
      end
   end

   // A final word flushes the accumulator and returns it to the empty state.
   always_comb begin
      if (req_data.last_value) begin
         acc_in  = '0;
         free_in = FREE_BITS'(WORD_BITS);
      end else begin
         acc_in  = acc_mid;
         free_in = free_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         free_ff <= FREE_BITS'(WORD_BITS);
      end else if (accept) begin
         acc_ff  <= acc_in;
         free_ff <= free_in;
      end
   end

   // Build the queue entry holding the words this input gives.
   always_comb begin
      push_entry.second_word = acc_mid;
      if (!fits) begin
         push_entry.first_word   = split_word;
         push_entry.first_last   = 1'b0;
         push_entry.second_valid = req_data.last_value;
      end else begin
         push_entry.first_word   = acc_mid;
         push_entry.first_last   = 1'b1;
         push_entry.second_valid = 1'b0;
      end
      push = accept && (!fits || req_data.last_value);
   end

endmodule

>>> hw/rtl/mfp_queue.sv
`timescale 1ns / 1ps

module mfp_queue import mfp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      nonempty,
   output entry_type head
);

   entry_type            slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;

   assign full     = count_ff == QCNT_BITS'(QUEUE_DEPTH);
   assign nonempty = count_ff != '0;
   assign head     = slots_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_BITS'(push) - QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/mfp_back.sv
`timescale 1ns / 1ps

module mfp_back import mfp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      nonempty,
   input  entry_type head,
   output logic      pop,
   input  logic      rsp_stall,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    phase_ff, phase_in;
   logic    load;

   assign load = !rsp_valid_ff || !rsp_stall;

   // Take the next word from the head entry; an entry with two words is
   // released only after its second word has gone out.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      phase_in     = phase_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = nonempty;
         if (phase_ff) begin
            rsp_data_in.packed_word = head.second_word;
            rsp_data_in.last_word   = 1'b1;
         end else begin
            rsp_data_in.packed_word = head.first_word;
            rsp_data_in.last_word   = head.first_last;
         end
         if (nonempty) begin
            pop      = phase_ff || !head.second_valid;
            phase_in = !pop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/mfp_checker.sv
`timescale 1ns / 1ps

module mfp_checker import mfp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data,
   input logic    csr_ready
);

   // A stalled output word stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled output word changed or dropped");

   // Coming out of reset nothing is offered and input is open.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // The input stalls only when the queue is full, which needs a word on offer.
   a_stall_has_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no output word on offer");

   // Configuration writes are always taken.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port not ready");

endmodule

bind msb_first_field_packer mfp_checker u_mfp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);
